/* rtl/fcn_pkg.sv */
// Shared types and constants of the normalized FIR convolution block.
// Used by the channel interfaces and by every module under rtl/.
// Depends on nothing.
package fcn_pkg;

   // Field widths of items, registers and datapath.
   localparam int SAMPLE_W  = 16;
   localparam int IDX_W     = 14;
   localparam int TAPCNT_W  = 15;
   localparam int GAIN_W    = 24;
   localparam int ACC_W     = 48;
   localparam int PROD_W    = 2 * SAMPLE_W;
   localparam int PSUM_W    = PROD_W + 2;
   localparam int ACC_SHIFT = 15;
   localparam int OUT_SHIFT = 16;
   localparam int SCL_W     = ACC_W - ACC_SHIFT;
   localparam int MUL_W     = SCL_W + GAIN_W + 1;

   // Four taps are worked on in every cycle of the run state, one per memory bank.
   localparam int LANES  = 4;
   localparam int LANE_W = 2;

   // Configuration port.
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   // Item function codes.
   localparam logic FUNC_LOAD   = 1'b0;
   localparam logic FUNC_FILTER = 1'b1;

   // Register indexes, taken from paddr[2].
   localparam logic REG_TAP_COUNT = 1'b0;
   localparam logic REG_OUT_GAIN  = 1'b1;

   // Register reset values.
   localparam logic [TAPCNT_W-1:0] TAP_COUNT_RST = 15'd4;
   localparam logic [GAIN_W-1:0]   OUT_GAIN_RST  = 24'd65536;

   // Saturation limits of the result.
   localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = 16'sh7FFF;
   localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = 16'sh8000;

   typedef logic signed [SAMPLE_W-1:0] sample_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_RUN,
      ST_DRAIN,
      ST_SCALE,
      ST_FINISH
   } state_type;

   // Control from the sequencer to the MAC datapath.
   typedef struct packed {
      logic acc_clr;
      logic rd_vld;
      logic scale;
   } mac_ctl_type;

endpackage

/* rtl/fcn_req_if.sv */
// Input channel of the FIR block: valid/ready plus one item payload.
// Depends on fcn_pkg for the field widths.
interface fcn_req_if;
   logic                              valid;
   logic                              ready;
   logic                              func;
   logic [fcn_pkg::IDX_W-1:0]         coef_index;
   logic signed [fcn_pkg::SAMPLE_W-1:0] coef_value;
   logic signed [fcn_pkg::SAMPLE_W-1:0] sample_in;

   modport source(output valid, func, coef_index, coef_value, sample_in, input ready);
   modport sink(input valid, func, coef_index, coef_value, sample_in, output ready);
endinterface

/* rtl/fcn_rsp_if.sv */
// Result channel of the FIR block: valid/ready plus one result payload.
// Depends on fcn_pkg for the field widths.
interface fcn_rsp_if;
   logic                                valid;
   logic                                ready;
   logic signed [fcn_pkg::SAMPLE_W-1:0] sample_out;
   logic                                saturated;

   modport source(output valid, sample_out, saturated, input ready);
   modport sink(input valid, sample_out, saturated, output ready);
endinterface

/* rtl/fcn_coef_mem.sv */
// Coefficient memory: four banks, coefficient i in bank i mod 4, row i/4.
// One coefficient is written per load; one row of four is read per cycle while rd_en is high.
// Depends on fcn_pkg.
module fcn_coef_mem #(
   parameter int MAX_TAPS = 16384,
   localparam int AW   = $clog2(MAX_TAPS),
   localparam int ROWS = MAX_TAPS / 4,
   localparam int RW   = (ROWS > 1) ? $clog2(ROWS) : 1
) (
   input  logic                 clock,
   input  logic                 wr_en,
   input  logic [AW-1:0]        wr_idx,
   input  fcn_pkg::sample_type  wr_data,
   input  logic                 rd_en,
   input  logic [RW-1:0]        rd_row,
   output fcn_pkg::sample_type  rd_data [fcn_pkg::LANES]
);

   logic [RW-1:0] wr_row;

   assign wr_row = RW'(wr_idx >> 2);

   for (genvar b = 0; b < fcn_pkg::LANES; b++) begin : g_bank
      localparam logic [fcn_pkg::LANE_W-1:0] BANK = fcn_pkg::LANE_W'(b);

      fcn_pkg::sample_type mem [ROWS];
      fcn_pkg::sample_type rd_data_ff;

      // Write one entry; the read of the row is registered.
      always_ff @(posedge clock) begin
         if (wr_en && (wr_idx[fcn_pkg::LANE_W-1:0] == BANK)) begin
            mem[wr_row] <= wr_data;
         end
         if (rd_en) begin
            rd_data_ff <= mem[rd_row];
         end
      end

      assign rd_data[b] = rd_data_ff;
   end

endmodule

/* rtl/fcn_hist_mem.sv */
// Sample history memory: four banks, position p in bank p mod 4, row p/4.
// Reads four consecutive positions from any start, wrapping modulo MAX_TAPS,
// and supports a row-wide clear used after reset. Depends on fcn_pkg.
module fcn_hist_mem #(
   parameter int MAX_TAPS = 16384,
   localparam int AW   = $clog2(MAX_TAPS),
   localparam int ROWS = MAX_TAPS / 4,
   localparam int RW   = (ROWS > 1) ? $clog2(ROWS) : 1
) (
   input  logic                 clock,
   input  logic                 clr_en,
   input  logic [RW-1:0]        clr_row,
   input  logic                 wr_en,
   input  logic [AW-1:0]        wr_pos,
   input  fcn_pkg::sample_type  wr_data,
   input  logic                 rd_en,
   input  logic [AW-1:0]        rd_pos,
   output fcn_pkg::sample_type  rd_data [fcn_pkg::LANES]
);

   logic [RW-1:0] wr_row;

   assign wr_row = RW'(wr_pos >> 2);

   for (genvar b = 0; b < fcn_pkg::LANES; b++) begin : g_bank
      localparam logic [fcn_pkg::LANE_W-1:0] BANK = fcn_pkg::LANE_W'(b);

      fcn_pkg::sample_type         mem [ROWS];
      fcn_pkg::sample_type         rd_data_ff;
      logic [fcn_pkg::LANE_W-1:0]  ofs;
      logic [AW:0]                 pos_sum;
      logic [AW:0]                 pos_wrap;
      logic [RW-1:0]               rd_row;

      // The position of this read group that falls into this bank.
      assign ofs      = BANK - rd_pos[fcn_pkg::LANE_W-1:0];
      assign pos_sum  = {1'b0, rd_pos} + (AW+1)'(ofs);
      assign pos_wrap = (pos_sum >= (AW+1)'(MAX_TAPS)) ? pos_sum - (AW+1)'(MAX_TAPS)
                                                       : pos_sum;
      assign rd_row   = RW'(pos_wrap >> 2);

      // Clear or write one entry; the read of one entry is registered.
      always_ff @(posedge clock) begin
         if (clr_en) begin
            mem[clr_row] <= '0;
         end else if (wr_en && (wr_pos[fcn_pkg::LANE_W-1:0] == BANK)) begin
            mem[wr_row] <= wr_data;
         end
         if (rd_en) begin
            rd_data_ff <= mem[rd_row];
         end
      end

      assign rd_data[b] = rd_data_ff;
   end

endmodule

/* rtl/fcn_mac.sv */
// Four-lane multiply-accumulate datapath with output gain and saturation.
// Takes one row of coefficients and history per cycle from the memories while reads are valid.
// Depends on fcn_pkg.
module fcn_mac (
   input  logic                          clock,
   input  logic                          reset,
   input  fcn_pkg::mac_ctl_type          ctl,
   input  logic [fcn_pkg::GAIN_W-1:0]    gain,
   input  logic [fcn_pkg::LANE_W-1:0]    rot,
   input  fcn_pkg::sample_type           coef [fcn_pkg::LANES],
   input  fcn_pkg::sample_type           hist [fcn_pkg::LANES],
   output logic                          busy,
   output fcn_pkg::sample_type           sample_out,
   output logic                          saturated
);

   localparam int TOP_LSB = fcn_pkg::OUT_SHIFT + fcn_pkg::SAMPLE_W - 1;

   logic                                 s1_vld_ff, s2_vld_ff, s3_vld_ff;
   logic signed [fcn_pkg::PROD_W-1:0]    prod_ff [fcn_pkg::LANES];
   logic signed [fcn_pkg::PROD_W-1:0]    prod_in [fcn_pkg::LANES];
   logic signed [fcn_pkg::PSUM_W-1:0]    psum_ff, psum_in;
   logic signed [fcn_pkg::ACC_W-1:0]     acc_ff, acc_in;
   logic signed [fcn_pkg::MUL_W-1:0]     mul_ff, mul_in;
   logic signed [fcn_pkg::SCL_W-1:0]     acc_scl;
   logic signed [fcn_pkg::GAIN_W:0]      gain_s;
   logic [fcn_pkg::MUL_W-1-TOP_LSB:0]    top_bits;

   // Valid flags of the three pipeline stages behind the memory read.
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
         s2_vld_ff <= 1'b0;
         s3_vld_ff <= 1'b0;
      end else begin
         s1_vld_ff <= ctl.rd_vld;
         s2_vld_ff <= s1_vld_ff;
         s3_vld_ff <= s2_vld_ff;
      end
   end

   assign busy = s1_vld_ff | s2_vld_ff | s3_vld_ff;

   // Products: history banks are rotated so lane k holds tap 4g+k.
   always_comb begin
      for (int k = 0; k < fcn_pkg::LANES; k++) begin
         prod_in[k] = fcn_pkg::PROD_W'(coef[k])
                    * fcn_pkg::PROD_W'(hist[fcn_pkg::LANE_W'(rot + fcn_pkg::LANE_W'(k))]);
      end
   end

   // Sum of the four lane products.
   always_comb begin
      psum_in = '0;
      for (int k = 0; k < fcn_pkg::LANES; k++) begin
         psum_in = psum_in + fcn_pkg::PSUM_W'(prod_ff[k]);
      end
   end

   // Accumulator, cleared when a filter item is taken.
   always_comb begin
      acc_in = acc_ff;
      if (ctl.acc_clr) begin
         acc_in = '0;
      end else if (s3_vld_ff) begin
         acc_in = acc_ff + fcn_pkg::ACC_W'(psum_ff);
      end
   end

   // Output gain: (acc >> 15) times the unsigned gain.
   assign acc_scl = fcn_pkg::SCL_W'(acc_ff >>> fcn_pkg::ACC_SHIFT);
   assign gain_s  = {1'b0, gain};
   assign mul_in  = fcn_pkg::MUL_W'(acc_scl) * fcn_pkg::MUL_W'(gain_s);

   always_ff @(posedge clock) begin
      if (s1_vld_ff) begin
         prod_ff <= prod_in;
      end
      if (s2_vld_ff) begin
         psum_ff <= psum_in;
      end
      acc_ff <= acc_in;
      if (ctl.scale) begin
         mul_ff <= mul_in;
      end
   end

   // Saturation of (product >> 16) to 16 bits.
   assign top_bits = mul_ff[fcn_pkg::MUL_W-1:TOP_LSB];

   always_comb begin
      if ((&top_bits) || !(|top_bits)) begin
         sample_out = mul_ff[TOP_LSB:fcn_pkg::OUT_SHIFT];
         saturated  = 1'b0;
      end else begin
         sample_out = mul_ff[fcn_pkg::MUL_W-1] ? fcn_pkg::SAMPLE_MIN : fcn_pkg::SAMPLE_MAX;
         saturated  = 1'b1;
      end
   end

endmodule

/* rtl/fir_convolution_normalized.sv */
// Top level of the normalized long FIR filter: sequencer, registers, output stage.
// Depends on fcn_pkg, fcn_req_if, fcn_rsp_if, fcn_coef_mem, fcn_hist_mem, fcn_mac.
//
//   Channel  Dir  Handshake                Payload
//   req      in   valid/ready              func, coef_index, coef_value, sample_in
//   rsp      out  valid/ready              sample_out, saturated
//   csr      in   psel/penable, pready=1   paddr, pwdata, prdata (tap_count, out_gain)
//
// A load item is taken in the idle state. A filter item runs through the run state, one row
// of each four-bank memory per cycle, then drain, scaling and finish; with fewer than four
// taps it skips the run state. After reset the history memory is cleared one row per cycle
// while req.ready stays low; register writes are taken throughout.
// A waiting result stalls only the end of the next filter item, not its acceptance.
module fir_convolution_normalized #(
   parameter int MAX_TAPS = 16384
) (
   input  logic                               clock,
   input  logic                               reset,
   fcn_req_if.sink                            req,
   fcn_rsp_if.source                          rsp,
   input  logic                               psel,
   input  logic                               penable,
   input  logic                               pwrite,
   input  logic [fcn_pkg::CSR_ADDR_W-1:0]     paddr,
   input  logic [fcn_pkg::CSR_DATA_W-1:0]     pwdata,
   output logic [fcn_pkg::CSR_DATA_W-1:0]     prdata,
   output logic                               pready
);

   localparam int AW   = $clog2(MAX_TAPS);
   localparam int ROWS = MAX_TAPS / 4;
   localparam int RW   = (ROWS > 1) ? $clog2(ROWS) : 1;
   localparam int GW   = $clog2(ROWS + 1);
   localparam int CW   = $clog2(MAX_TAPS + 1);

   fcn_pkg::state_type                 state_ff, state_in;
   logic [fcn_pkg::TAPCNT_W-1:0]       tap_count_ff;
   logic [fcn_pkg::GAIN_W-1:0]         out_gain_ff;
   logic [AW-1:0]                      write_pos_ff, write_pos_in;
   logic [RW-1:0]                      clr_row_ff, clr_row_in;
   logic [RW-1:0]                      grp_ff, grp_in;
   logic [AW-1:0]                      rd_pos_ff, rd_pos_in;
   logic [GW-1:0]                      ngroups_ff, ngroups_in;
   logic                               rsp_valid_ff, rsp_valid_in;
   fcn_pkg::sample_type                rsp_sample_ff;
   logic                               rsp_sat_ff;

   logic                               csr_wr;
   logic                               req_xfer;
   logic                               clr_en;
   logic                               hist_wr;
   logic                               coef_wr;
   logic                               rsp_load;
   fcn_pkg::mac_ctl_type               mac_ctl;
   logic                               mac_busy;
   fcn_pkg::sample_type                mac_sample;
   logic                               mac_sat;
   fcn_pkg::sample_type                coef_rd [fcn_pkg::LANES];
   fcn_pkg::sample_type                hist_rd [fcn_pkg::LANES];
   logic [31:0]                        taps_req;
   logic [CW-1:0]                      taps_lim;
   logic [GW-1:0]                      ngroups_new;
   logic [AW:0]                        step_sum;
   logic                               last_grp;

   // Configuration registers; the register index is paddr[2].
   assign pready = 1'b1;
   assign csr_wr = psel & penable & pwrite & pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         tap_count_ff <= fcn_pkg::TAP_COUNT_RST;
         out_gain_ff  <= fcn_pkg::OUT_GAIN_RST;
      end else if (csr_wr) begin
         case (paddr[2])
            fcn_pkg::REG_TAP_COUNT: tap_count_ff <= pwdata[fcn_pkg::TAPCNT_W-1:0];
            fcn_pkg::REG_OUT_GAIN:  out_gain_ff  <= pwdata[fcn_pkg::GAIN_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (paddr[2])
         fcn_pkg::REG_TAP_COUNT: prdata = fcn_pkg::CSR_DATA_W'(tap_count_ff);
         fcn_pkg::REG_OUT_GAIN:  prdata = fcn_pkg::CSR_DATA_W'(out_gain_ff);
         default:                prdata = '0;
      endcase
   end

   // Effective tap count in groups of four, capped at MAX_TAPS.
   assign taps_req    = 32'(tap_count_ff);
   assign taps_lim    = (taps_req > 32'(MAX_TAPS)) ? CW'(MAX_TAPS) : CW'(taps_req);
   assign ngroups_new = GW'(taps_lim >> 2);

   assign step_sum = {1'b0, rd_pos_ff} + (AW+1)'(fcn_pkg::LANES);
   assign last_grp = (GW'(grp_ff) == (ngroups_ff - GW'(1)));

   assign req.ready = (state_ff == fcn_pkg::ST_IDLE);
   assign req_xfer  = req.valid & req.ready;

   // Sequencer: next state and control.
   always_comb begin
      state_in     = state_ff;
      clr_row_in   = clr_row_ff;
      grp_in       = grp_ff;
      rd_pos_in    = rd_pos_ff;
      ngroups_in   = ngroups_ff;
      write_pos_in = write_pos_ff;
      clr_en       = 1'b0;
      hist_wr      = 1'b0;
      coef_wr      = 1'b0;
      rsp_load     = 1'b0;
      mac_ctl      = '0;

      case (state_ff)
         fcn_pkg::ST_CLEAR: begin
            clr_en     = 1'b1;
            clr_row_in = clr_row_ff + RW'(1);
            if (clr_row_ff == RW'(ROWS - 1)) begin
               state_in = fcn_pkg::ST_IDLE;
            end
         end
         fcn_pkg::ST_IDLE: begin
            if (req_xfer) begin
               if (req.func == fcn_pkg::FUNC_FILTER) begin
                  hist_wr         = 1'b1;
                  mac_ctl.acc_clr = 1'b1;
                  rd_pos_in       = write_pos_ff;
                  grp_in          = '0;
                  ngroups_in      = ngroups_new;
                  state_in        = (ngroups_new == '0) ? fcn_pkg::ST_DRAIN
                                                        : fcn_pkg::ST_RUN;
               end else begin
                  coef_wr = (32'(req.coef_index) < MAX_TAPS);
               end
            end
         end
         fcn_pkg::ST_RUN: begin
            mac_ctl.rd_vld = 1'b1;
            if (last_grp) begin
               state_in = fcn_pkg::ST_DRAIN;
            end else begin
               grp_in    = grp_ff + RW'(1);
               rd_pos_in = AW'((step_sum >= (AW+1)'(MAX_TAPS))
                               ? step_sum - (AW+1)'(MAX_TAPS) : step_sum);
            end
         end
         fcn_pkg::ST_DRAIN: begin
            if (!mac_busy) begin
               state_in = fcn_pkg::ST_SCALE;
            end
         end
         fcn_pkg::ST_SCALE: begin
            mac_ctl.scale = 1'b1;
            state_in      = fcn_pkg::ST_FINISH;
         end
         fcn_pkg::ST_FINISH: begin
            if (!rsp_valid_ff || rsp.ready) begin
               rsp_load     = 1'b1;
               write_pos_in = (write_pos_ff == '0) ? AW'(MAX_TAPS - 1)
                                                   : write_pos_ff - AW'(1);
               state_in     = fcn_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = fcn_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= fcn_pkg::ST_CLEAR;
         clr_row_ff   <= '0;
         write_pos_ff <= '0;
         grp_ff       <= '0;
         rd_pos_ff    <= '0;
         ngroups_ff   <= '0;
      end else begin
         state_ff     <= state_in;
         clr_row_ff   <= clr_row_in;
         write_pos_ff <= write_pos_in;
         grp_ff       <= grp_in;
         rd_pos_ff    <= rd_pos_in;
         ngroups_ff   <= ngroups_in;
      end
   end

   // Output register: a result waits here until its transfer.
   assign rsp_valid_in = rsp_load | (rsp_valid_ff & ~rsp.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_sample_ff <= mac_sample;
         rsp_sat_ff    <= mac_sat;
      end
   end

   assign rsp.valid      = rsp_valid_ff;
   assign rsp.sample_out = rsp_sample_ff;
   assign rsp.saturated  = rsp_sat_ff;

   // Memories and datapath.
   fcn_coef_mem #(
      .MAX_TAPS (MAX_TAPS)
   ) u_coef_mem (
      .clock   (clock),
      .wr_en   (coef_wr),
      .wr_idx  (AW'(req.coef_index)),
      .wr_data (req.coef_value),
      .rd_en   (mac_ctl.rd_vld),
      .rd_row  (grp_ff),
      .rd_data (coef_rd)
   );

   fcn_hist_mem #(
      .MAX_TAPS (MAX_TAPS)
   ) u_hist_mem (
      .clock   (clock),
      .clr_en  (clr_en),
      .clr_row (clr_row_ff),
      .wr_en   (hist_wr),
      .wr_pos  (write_pos_ff),
      .wr_data (req.sample_in),
      .rd_en   (mac_ctl.rd_vld),
      .rd_pos  (rd_pos_ff),
      .rd_data (hist_rd)
   );

   fcn_mac u_mac (
      .clock      (clock),
      .reset      (reset),
      .ctl        (mac_ctl),
      .gain       (out_gain_ff),
      .rot        (write_pos_ff[fcn_pkg::LANE_W-1:0]),
      .coef       (coef_rd),
      .hist       (hist_rd),
      .busy       (mac_busy),
      .sample_out (mac_sample),
      .saturated  (mac_sat)
   );

endmodule

/* tb/sv/fir_convolution_normalized_tb.sv */
// Self-checking testbench for the normalized long FIR filter (fir_convolution_normalized).
// It drives coefficient loads and samples, predicts every filtered result and checks
// each one. Depends on fcn_pkg, fcn_req_if, fcn_rsp_if and the RTL of the block.
module fir_convolution_normalized_tb;

   localparam int MAX_TAPS          = 16384;
   localparam int CLK_PERIOD        = 4;
   localparam int RESET_CYCLES      = 12;
   localparam int SETTLE_CYCLES     = 24;
   localparam int RANDOM_PHASES     = 7;
   localparam int PHASE_ITEMS       = 14;
   localparam int PAUSE_PHASE       = 2;
   localparam int LONG_STALL_PHASE  = 4;
   localparam int LONG_STALL_CYCLES = 400;
   localparam int COEF_PRELOAD      = 24;
   localparam int TIMEOUT_CYCLES    = 1500000;
   localparam int REPORT_LIMIT      = 10;

   // One item on the input channel.
   typedef struct {
      logic                          func;
      logic [fcn_pkg::IDX_W-1:0]     coef_index;
      fcn_pkg::sample_type           coef_value;
      fcn_pkg::sample_type           sample_in;
   } fir_item_type;

   // One result on the output channel.
   typedef struct {
      fcn_pkg::sample_type sample_out;
      logic                saturated;
   } fir_result_type;

   logic                           clock;
   logic                           reset   = 1'b1;
   logic                           psel    = 1'b0;
   logic                           penable = 1'b0;
   logic                           pwrite  = 1'b0;
   logic [fcn_pkg::CSR_ADDR_W-1:0] paddr   = '0;
   logic [fcn_pkg::CSR_DATA_W-1:0] pwdata  = '0;
   logic [fcn_pkg::CSR_DATA_W-1:0] prdata;
   logic                           pready;

   fcn_req_if req_bus ();
   fcn_rsp_if rsp_bus ();

   fir_convolution_normalized #(
      .MAX_TAPS(MAX_TAPS)
   ) dut (
      .clock   (clock),
      .reset   (reset),
      .req     (req_bus),
      .rsp     (rsp_bus),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready)
   );

   // Items waiting to be offered and filtered samples waiting to come out.
   fir_item_type   fir_item_q[$];
   fir_result_type expected_samples_q[$];

   // Own copy of the filter state and of the two registers.
   fcn_pkg::sample_type          coef_table [MAX_TAPS];
   fcn_pkg::sample_type          sample_history [MAX_TAPS] = '{default: '0};
   int unsigned                  newest_pos   = 0;
   logic [fcn_pkg::TAPCNT_W-1:0] taps_setting = fcn_pkg::TAP_COUNT_RST;
   logic [fcn_pkg::GAIN_W-1:0]   gain_setting = fcn_pkg::OUT_GAIN_RST;

   int error_count   = 0;
   int load_count    = 0;
   int filter_count  = 0;
   int clip_count    = 0;
   int setting_count = 0;
   int phase_num     = 0;

   int   burst_left = 0;
   int   gap_left   = 0;
   logic rsp_block  = 1'b0;
   int   rsp_mode   = 0;
   int   mode_left  = 0;
   logic [2:0] rsp_tick = '0;

   // Free-running clock.
   initial begin
      clock = 1'b0;
      forever #(CLK_PERIOD / 2) clock = ~clock;
   end

   task automatic flag_error(input string what);
      error_count++;
      if (error_count <= REPORT_LIMIT) begin
         $display("ERROR at %0t: %s", $time, what);
      end
   endtask

   // Apply one accepted item to the filter state and queue the result of a filter item.
   function automatic void apply_fir_item(input fir_item_type it);
      int unsigned    active_taps;
      int unsigned    pos;
      longint         acc;
      longint         scaled;
      fir_result_type res;
      if (it.func == fcn_pkg::FUNC_LOAD) begin
         if (it.coef_index < MAX_TAPS) begin
            coef_table[it.coef_index] = it.coef_value;
         end
         load_count++;
      end else begin
         sample_history[newest_pos] = it.sample_in;
         active_taps = (taps_setting > MAX_TAPS) ? MAX_TAPS : taps_setting;
         active_taps = active_taps & ~32'd3;
         acc = 0;
         pos = newest_pos;
         for (int i = 0; i < active_taps; i++) begin
            acc += longint'(coef_table[i]) * longint'(sample_history[pos]);
            pos = (pos + 1) % MAX_TAPS;
         end
         scaled = ((acc >>> fcn_pkg::ACC_SHIFT) * longint'(gain_setting))
                  >>> fcn_pkg::OUT_SHIFT;
         res.saturated = 1'b1;
         if (scaled > 32767) begin
            res.sample_out = fcn_pkg::SAMPLE_MAX;
         end else if (scaled < -32768) begin
            res.sample_out = fcn_pkg::SAMPLE_MIN;
         end else begin
            res.sample_out = scaled[fcn_pkg::SAMPLE_W-1:0];
            res.saturated  = 1'b0;
         end
         if (res.saturated) begin
            clip_count++;
         end
         expected_samples_q.push_back(res);
         newest_pos = (newest_pos == 0) ? MAX_TAPS - 1 : newest_pos - 1;
         filter_count++;
      end
   endfunction

   // Sender: offers queued items in bursts of random length with random gaps.
   always @(posedge clock) begin : item_driver
      fir_item_type next_item;
      if (reset) begin
         req_bus.valid <= 1'b0;
         burst_left = $urandom_range(1, 24);
         gap_left   = 0;
      end else begin
         if (req_bus.valid && req_bus.ready) begin
            apply_fir_item(fir_item_q.pop_front());
         end
         if (req_bus.valid && !req_bus.ready) begin
            // The offered item stays on the channel until its transfer.
         end else if (gap_left > 0) begin
            gap_left--;
            req_bus.valid <= 1'b0;
         end else if (fir_item_q.size() > 0) begin
            next_item = fir_item_q[0];
            req_bus.valid      <= 1'b1;
            req_bus.func       <= next_item.func;
            req_bus.coef_index <= next_item.coef_index;
            req_bus.coef_value <= next_item.coef_value;
            req_bus.sample_in  <= next_item.sample_in;
            if (burst_left <= 1) begin
               burst_left = $urandom_range(1, 24);
               case ($urandom_range(0, 5))
                  0, 1:    gap_left = 0;
                  5:       gap_left = $urandom_range(5, 12);
                  default: gap_left = $urandom_range(1, 4);
               endcase
            end else begin
               burst_left--;
            end
         end else begin
            req_bus.valid <= 1'b0;
         end
      end
   end

   // Receiver: switches between always ready, random stalls and one cycle in eight.
   always @(posedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
         mode_left = 0;
      end else begin
         rsp_tick <= rsp_tick + 1'b1;
         if (mode_left == 0) begin
            rsp_mode  = $urandom_range(0, 2);
            mode_left = $urandom_range(16, 96);
         end else begin
            mode_left--;
         end
         case (rsp_mode)
            0:       rsp_bus.ready <= !rsp_block;
            1:       rsp_bus.ready <= !rsp_block && ($urandom_range(0, 1) == 1);
            default: rsp_bus.ready <= !rsp_block && (rsp_tick == 3'd0);
         endcase
      end
   end

   // One long hold-off of the receiver, so that the block backs up into its input.
   initial begin
      wait (phase_num == LONG_STALL_PHASE);
      @(posedge clock);
      rsp_block <= 1'b1;
      repeat (LONG_STALL_CYCLES) @(posedge clock);
      rsp_block <= 1'b0;
   end

   // Compare every result transfer with the oldest prediction.
   always @(posedge clock) begin : result_monitor
      fir_result_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (expected_samples_q.size() == 0) begin
            flag_error($sformatf("unexpected result sample_out=%0d saturated=%0b",
                                 rsp_bus.sample_out, rsp_bus.saturated));
         end else begin
            want = expected_samples_q.pop_front();
            if (rsp_bus.sample_out !== want.sample_out ||
                rsp_bus.saturated !== want.saturated) begin
               flag_error($sformatf("expected sample_out=%0d saturated=%0b, got %0d %0b",
                                    want.sample_out, want.saturated,
                                    rsp_bus.sample_out, rsp_bus.saturated));
            end
         end
      end
   end

   // Register write: setup cycle, then access cycle until pready.
   task automatic write_reg(input logic reg_sel,
                            input logic [fcn_pkg::CSR_DATA_W-1:0] value);
      @(posedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {reg_sel, 2'b00};
      pwdata  <= value;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      if (reg_sel == fcn_pkg::REG_TAP_COUNT) begin
         taps_setting = value[fcn_pkg::TAPCNT_W-1:0];
      end else begin
         gain_setting = value[fcn_pkg::GAIN_W-1:0];
      end
   endtask

   // Register read, compared with the value the register should hold.
   task automatic check_reg(input logic reg_sel,
                            input logic [fcn_pkg::CSR_DATA_W-1:0] want);
      @(posedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      paddr   <= {reg_sel, 2'b00};
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      if (prdata !== want) begin
         flag_error($sformatf("register %0d read expected %0d, got %0d",
                              reg_sel, want, prdata));
      end
      psel    <= 1'b0;
      penable <= 1'b0;
   endtask

   task automatic set_config(input int unsigned taps, input int unsigned gain);
      write_reg(fcn_pkg::REG_TAP_COUNT, taps & 32'h7FFF);
      write_reg(fcn_pkg::REG_OUT_GAIN, gain & 32'hFF_FFFF);
      check_reg(fcn_pkg::REG_TAP_COUNT, taps & 32'h7FFF);
      check_reg(fcn_pkg::REG_OUT_GAIN, gain & 32'hFF_FFFF);
      setting_count++;
   endtask

   function automatic void push_item(input logic func, input int unsigned idx,
                                     input int unsigned value, input int unsigned sample);
      fir_item_type it;
      it.func       = func;
      it.coef_index = idx[fcn_pkg::IDX_W-1:0];
      it.coef_value = value[fcn_pkg::SAMPLE_W-1:0];
      it.sample_in  = sample[fcn_pkg::SAMPLE_W-1:0];
      fir_item_q.push_back(it);
   endfunction

   // Samples lean on full scale, zero and one LSB around zero.
   function automatic int unsigned rand_sample();
      case ($urandom_range(0, 9))
         0:       return 32'h7FFF;
         1:       return 32'h8000;
         2:       return $urandom_range(0, 2) - 1;
         default: return $urandom;
      endcase
   endfunction

   // Wait until every item is taken and every result is in, then let the block settle.
   task automatic wait_drained(input int settle);
      while (fir_item_q.size() != 0 || expected_samples_q.size() != 0) @(posedge clock);
      repeat (settle) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic run_fixed_phase(input int unsigned taps, input int unsigned gain,
                                  input int n_filters);
      set_config(taps, gain);
      @(negedge clock);
      for (int k = 0; k < n_filters; k++) begin
         push_item(fcn_pkg::FUNC_FILTER, $urandom, $urandom, rand_sample());
      end
      wait_drained(SETTLE_CYCLES);
   endtask

   // Short filters over the loaded coefficients with random gain, mixed with loads.
   task automatic run_random_phase(input int n_items, input bit pause_midway);
      int unsigned taps;
      int unsigned gain;
      case ($urandom_range(0, 9))
         0:       taps = $urandom_range(0, 3);
         1:       taps = $urandom_range(16, COEF_PRELOAD);
         default: taps = $urandom_range(4, 16);
      endcase
      case ($urandom_range(0, 7))
         0:       gain = 0;
         1:       gain = 24'hFF_FFFF;
         2:       gain = fcn_pkg::OUT_GAIN_RST;
         default: gain = $urandom_range(1, 65535);
      endcase
      set_config(taps, gain);
      @(negedge clock);
      for (int k = 0; k < n_items; k++) begin
         if (pause_midway && k == n_items / 2) begin
            wait_drained(0);
         end
         if ($urandom_range(0, 3) == 0) begin
            push_item(fcn_pkg::FUNC_LOAD,
                      $urandom_range(0, 1) ? $urandom_range(0, 127)
                                           : $urandom_range(0, MAX_TAPS - 1),
                      $urandom, $urandom);
         end else begin
            push_item(fcn_pkg::FUNC_FILTER, $urandom, $urandom, rand_sample());
         end
      end
      wait_drained(SETTLE_CYCLES);
   endtask

   // Main sequence: reset, directed items, a short-filter phase, leading coefficients, random phases.
   initial begin : stimulus
      req_bus.valid      = 1'b0;
      req_bus.func       = fcn_pkg::FUNC_LOAD;
      req_bus.coef_index = '0;
      req_bus.coef_value = '0;
      req_bus.sample_in  = '0;
      rsp_bus.ready      = 1'b0;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      check_reg(fcn_pkg::REG_TAP_COUNT, fcn_pkg::TAP_COUNT_RST);
      check_reg(fcn_pkg::REG_OUT_GAIN, fcn_pkg::OUT_GAIN_RST);

      // Reset settings: four taps at unity gain, mostly full-scale coefficients and samples.
      @(negedge clock);
      push_item(fcn_pkg::FUNC_LOAD, 0, 32'h7FFF, 0);
      push_item(fcn_pkg::FUNC_LOAD, 1, 32'h8000, 32'hFFFF);
      push_item(fcn_pkg::FUNC_LOAD, 2, 32'h8000, 0);
      push_item(fcn_pkg::FUNC_LOAD, 3, 1, 32'hFFFF);
      push_item(fcn_pkg::FUNC_LOAD, MAX_TAPS - 1, 32'h8000, 32'h5555);
      push_item(fcn_pkg::FUNC_LOAD, 8191, 32'h7FFF, 32'hAAAA);
      push_item(fcn_pkg::FUNC_FILTER, 32'h3FFF, 32'hFFFF, 32'h7FFF);
      push_item(fcn_pkg::FUNC_FILTER, 0, 0, 32'h8000);
      push_item(fcn_pkg::FUNC_FILTER, 32'h2AAA, 32'h5555, 32'h8000);
      push_item(fcn_pkg::FUNC_FILTER, 32'h1555, 32'hAAAA, 0);
      push_item(fcn_pkg::FUNC_FILTER, 0, 0, 1);
      push_item(fcn_pkg::FUNC_LOAD, 3, 32'h8000, 32'h8000);
      push_item(fcn_pkg::FUNC_FILTER, 0, 0, 32'hFFFF);
      push_item(fcn_pkg::FUNC_FILTER, 0, 0, 32'h5555);
      push_item(fcn_pkg::FUNC_FILTER, 0, 0, 32'hAAAA);
      push_item(fcn_pkg::FUNC_FILTER, 0, 0, 0);
      wait_drained(SETTLE_CYCLES);

      // Fewer than four taps at the largest gain: every result is zero.
      run_fixed_phase(3, 24'hFF_FFFF, 3);

      // Load the leading coefficients so that every tap count used below is safe.
      @(negedge clock);
      for (int idx = 0; idx < COEF_PRELOAD; idx++) begin
         push_item(fcn_pkg::FUNC_LOAD, idx,
                   ($urandom_range(0, 15) == 0) ? 32'h8000 : $urandom, $urandom);
      end
      wait_drained(SETTLE_CYCLES);

      for (int p = 0; p < RANDOM_PHASES; p++) begin
         phase_num = p + 1;
         run_random_phase(PHASE_ITEMS, phase_num == PAUSE_PHASE);
      end

      $display("Covered %0d coefficient loads and %0d filtered samples (%0d clipped)",
               load_count, filter_count, clip_count);
      $display("over %0d register settings, from no taps up to %0d taps.",
               setting_count, COEF_PRELOAD);
      if (error_count == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("%0d mismatches in total.", error_count);
         $display("*** FAILED ***");
      end
      $finish;
   end

   // Watchdog against a hung handshake.
   initial begin
      #(TIMEOUT_CYCLES * CLK_PERIOD);
      $display("Timeout with %0d items pending and %0d results outstanding.",
               fir_item_q.size(), expected_samples_q.size());
      $display("*** FAILED ***");
      $finish;
   end

endmodule

/* filelist.f */
rtl/fcn_pkg.sv
rtl/fcn_req_if.sv
rtl/fcn_rsp_if.sv
rtl/fcn_coef_mem.sv
rtl/fcn_hist_mem.sv
rtl/fcn_mac.sv
rtl/fir_convolution_normalized.sv
tb/sv/fir_convolution_normalized_tb.sv
